// ===== hdl/detrap_pkg.sv =====
// Shared types and constants for the differential entropy trapezoid unit.
package detrap_pkg;

  localparam int SAMPLE_W = 32;
  localparam int RATE_W   = 16;
  localparam int CNT_W    = 17;
  localparam int ADDR_MW  = 16;
  localparam int ACC_W    = 50;
  localparam int USED_W   = 11;
  localparam int STAT_W   = 3;
  localparam int LP_W     = 6;
  localparam int FRAC_W   = 16;
  localparam int L_W      = LP_W + FRAC_W;
  localparam int PROD_W   = 31 + L_W;
  localparam int T_W      = 70;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FEW    = 3'd1,
    ST_NONPOS = 3'd2,
    ST_NEG    = 3'd3,
    ST_OVF    = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] entropy;
    status_t                    status;
    logic [USED_W-1:0]          samples_used;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [ACC_W-1:0] acc;
    logic                    neg;
    logic                    ovf;
  } job_t;

  typedef struct packed {
    logic                       en;
    logic [ADDR_MW-1:0]         addr;
    logic signed [SAMPLE_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== hdl/detrap_front.sv =====
// Front part: accepts samples, writes the store, accumulates the trapezoid sum.
module detrap_front import detrap_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_valid,
  input  logic     back_busy,
  output logic     q_push,
  output job_t     q_job,
  output mem_wr_t  wr
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       neg_r, neg_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       accept;
  logic                       store;
  logic signed [ACC_W-1:0]    pair;

  assign in_stall = q_valid || back_busy;
  assign accept   = in_valid && !in_stall;
  assign store    = cnt_r < CW'(MAX_SAMPLES);
  assign pair     = ACC_W'(prev_r) + ACC_W'(in_data.sample);

  always_comb begin
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    prev_nxt = prev_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (store) begin
        cnt_nxt  = cnt_r + CW'(1);
        prev_nxt = in_data.sample;
        neg_nxt  = neg_r || in_data.sample[SAMPLE_W-1];
        if (cnt_r != '0) begin
          acc_nxt = acc_r + pair;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign q_push      = accept && in_data.last;
  assign q_job.count = CNT_W'(cnt_nxt);
  assign q_job.acc   = acc_nxt;
  assign q_job.neg   = neg_nxt;
  assign q_job.ovf   = ovf_nxt;

  assign wr.en   = accept && store;
  assign wr.addr = ADDR_MW'(cnt_r);
  assign wr.data = in_data.sample;

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (!rst_n || q_push) begin
      cnt_r <= '0;
      acc_r <= '0;
      neg_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/detrap_queue.sv =====
// Two-entry job queue between the front and back parts.
module detrap_queue import detrap_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_valid = cnt_r != 2'd0;
  assign q_job   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) begin
      ent_r[wp_r] <= push_job;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && cnt_r != 2'd2) begin
        wp_r <= ~wp_r;
      end
      if (pop && q_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && cnt_r != 2'd2) ? 1 : 0) - 2'((pop && q_valid) ? 1 : 0);
    end
  end

endmodule

// ===== hdl/detrap_log.sv =====
// Iterative log2 unit, unsigned Q.16 result, one step per cycle.
module detrap_log import detrap_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] x,
  output logic             done,
  output logic [L_W-1:0]   res
);

  typedef enum logic [2:0] {
    LG_IDLE = 3'b001,
    LG_NORM = 3'b010,
    LG_FRAC = 3'b100
  } lstate_t;

  localparam logic [LP_W-1:0] P_START = LP_W'(30);

  lstate_t              st_r;
  logic [ACC_W-1:0]     m_r;
  logic [LP_W-1:0]      p_r;
  logic [FRAC_W-1:0]    f_r;
  logic [3:0]           b_r;
  logic                 done_r;
  logic [61:0]          sq;
  logic [31:0]          m2;

  assign sq   = 62'(m_r[30:0]) * 62'(m_r[30:0]);
  assign m2   = sq[61:30];
  assign done = done_r;
  assign res  = {p_r, f_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LG_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        LG_IDLE: begin
          if (start) begin
            m_r <= x;
            f_r <= '0;
            if (x == '0) begin
              p_r    <= '0;
              done_r <= 1'b1;
            end else begin
              p_r  <= P_START;
              st_r <= LG_NORM;
            end
          end
        end
        LG_NORM: begin
          if (m_r[ACC_W-1:31] != '0) begin
            m_r <= m_r >> 1;
            p_r <= p_r + LP_W'(1);
          end else if (!m_r[30]) begin
            m_r <= m_r << 1;
            p_r <= p_r - LP_W'(1);
          end else begin
            b_r  <= 4'd15;
            st_r <= LG_FRAC;
          end
        end
        LG_FRAC: begin
          f_r <= {f_r[FRAC_W-2:0], m2[31]};
          m_r <= m2[31] ? ACC_W'(m2[31:1]) : ACC_W'(m2);
          b_r <= b_r - 4'd1;
          if (b_r == 4'd0) begin
            done_r <= 1'b1;
            st_r   <= LG_IDLE;
          end
        end
        default: st_r <= LG_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/detrap_back.sv =====
// Back part: sample store, entropy compute pass, divider and output register.
module detrap_back import detrap_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_wr_t           wr,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  input  logic [RATE_W-1:0] rate,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int DC_W   = $clog2(T_W + 1);
  localparam int H_W    = T_W + 2;
  localparam logic signed [H_W-1:0] H_MAX = H_W'(64'd2147483647);
  localparam logic signed [H_W-1:0] H_MIN = ~H_MAX;

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_CLASS = 11'b00000000010,
    B_READ  = 11'b00000000100,
    B_LOAD  = 11'b00000001000,
    B_LOGV  = 11'b00000010000,
    B_ACC   = 11'b00000100000,
    B_LOGS  = 11'b00001000000,
    B_LOGR  = 11'b00010000000,
    B_DIV   = 11'b00100000000,
    B_FIN   = 11'b01000000000,
    B_EMIT  = 11'b10000000000
  } bstate_t;

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  bstate_t                    st_r;
  job_t                       job_r;
  logic [CNT_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic [PROD_W-1:0]          prod_r;
  logic [T_W-1:0]             t_r;
  logic [L_W-1:0]             ls_r, lr_r;
  logic [T_W-1:0]             dq_r;
  logic [ACC_W-1:0]           rem_r;
  logic [DC_W-1:0]            dc_r;
  logic signed [SAMPLE_W-1:0] ent_r;
  status_t                    stat_r;
  out_item_t                  out_r;
  logic                       out_valid_r;

  logic                       lg_start, lg_done;
  logic [ACC_W-1:0]           lg_x;
  logic [L_W-1:0]             lg_res;
  logic [ACC_W-1:0]           s_val;
  logic [RATE_W-1:0]          rate_eff;
  logic                       last_idx;
  logic                       wt2;
  logic [ACC_W-1:0]           rem_sh;
  logic                       ge;
  logic signed [H_W-1:0]      h;
  logic                       emit;

  detrap_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .x     (lg_x),
    .done  (lg_done),
    .res   (lg_res)
  );

  assign s_val    = job_r.acc;
  assign rate_eff = (rate == '0) ? RATE_W'(1) : rate;
  assign last_idx = idx_r == job_r.count - CNT_W'(1);
  assign wt2      = (idx_r != '0) && !last_idx;
  assign rem_sh   = {rem_r[ACC_W-2:0], dq_r[T_W-1]};
  assign ge       = rem_sh >= s_val;
  assign h        = $signed(H_W'(ls_r)) - $signed(H_W'(lr_r)) - $signed(H_W'(dq_r));
  assign emit     = (st_r == B_EMIT) && (!out_valid_r || !out_stall);
  assign busy     = st_r != B_IDLE;
  assign q_pop    = (st_r == B_IDLE) && q_valid;

  always_comb begin
    lg_start = 1'b0;
    lg_x     = s_val;
    case (st_r)
      B_LOAD: begin
        if (rd_r != '0) begin
          lg_start = 1'b1;
          lg_x     = ACC_W'(rd_r[30:0]);
        end else begin
          lg_start = last_idx;
        end
      end
      B_ACC:  lg_start = last_idx;
      B_LOGS: begin
        lg_start = lg_done;
        lg_x     = ACC_W'({rate_eff, 1'b0});
      end
      default: lg_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (st_r == B_READ) begin
      rd_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            job_r <= q_job;
            st_r  <= B_CLASS;
          end
        end
        B_CLASS: begin
          ent_r <= '0;
          idx_r <= '0;
          t_r   <= '0;
          if (job_r.count < CNT_W'(2)) begin
            stat_r <= ST_FEW;
            st_r   <= B_EMIT;
          end else if (job_r.acc <= 0) begin
            stat_r <= ST_NONPOS;
            st_r   <= B_EMIT;
          end else if (job_r.neg) begin
            stat_r <= ST_NEG;
            st_r   <= B_EMIT;
          end else begin
            st_r <= B_READ;
          end
        end
        B_READ: st_r <= B_LOAD;
        B_LOAD: begin
          if (rd_r != '0) begin
            st_r <= B_LOGV;
          end else if (last_idx) begin
            st_r <= B_LOGS;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
            st_r  <= B_READ;
          end
        end
        B_LOGV: begin
          if (lg_done) begin
            prod_r <= PROD_W'(rd_r[30:0]) * PROD_W'(lg_res);
            st_r   <= B_ACC;
          end
        end
        B_ACC: begin
          t_r <= t_r + (wt2 ? T_W'({prod_r, 1'b0}) : T_W'(prod_r));
          if (last_idx) begin
            st_r <= B_LOGS;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
            st_r  <= B_READ;
          end
        end
        B_LOGS: begin
          if (lg_done) begin
            ls_r <= lg_res;
            st_r <= B_LOGR;
          end
        end
        B_LOGR: begin
          if (lg_done) begin
            lr_r  <= lg_res;
            dq_r  <= t_r;
            rem_r <= '0;
            dc_r  <= DC_W'(T_W);
            st_r  <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r <= ge ? rem_sh - s_val : rem_sh;
          dq_r  <= {dq_r[T_W-2:0], ge};
          dc_r  <= dc_r - DC_W'(1);
          if (dc_r == DC_W'(1)) begin
            st_r <= B_FIN;
          end
        end
        B_FIN: begin
          if (h > H_MAX) begin
            ent_r <= SAMPLE_W'(H_MAX);
          end else if (h < H_MIN) begin
            ent_r <= SAMPLE_W'(H_MIN);
          end else begin
            ent_r <= SAMPLE_W'(h);
          end
          stat_r <= job_r.ovf ? ST_OVF : ST_OK;
          st_r   <= B_EMIT;
        end
        B_EMIT: begin
          if (emit) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.entropy      <= ent_r;
      out_r.status       <= stat_r;
      out_r.samples_used <= job_r.count[USED_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/differential_entropy_trapezoid_unit.sv =====
// Top level of the differential entropy trapezoid unit.
//
//   channel  | handshake          | payload
//   in       | in_valid/in_stall  | in_data (sample, last)
//   out      | out_valid/out_stall| out_data (entropy, status, samples_used)
//   cfg      | cfg_wr_en          | cfg_wr_data (sample_rate)
//
// A sample without last is accepted whenever in_stall is low. After last the
// input stalls for the compute pass: per nonzero sample a store read, up to 30
// normalize and 16 squaring steps in the shared log2 unit and an accumulate
// step; then two more log2 runs and a restoring divide. Errors skip the
// compute pass. Reset is synchronous; the store needs no clearing. The output
// register holds a result while out_stall is high.
module differential_entropy_trapezoid_unit import detrap_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data
);

  logic [RATE_W-1:0] rate_r;
  logic              q_push, q_pop, q_valid, back_busy;
  job_t              push_job, q_job;
  mem_wr_t           wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_W'(1);
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  detrap_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_valid   (q_valid),
    .back_busy (back_busy),
    .q_push    (q_push),
    .q_job     (push_job),
    .wr        (wr)
  );

  detrap_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  detrap_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .rate      (rate_r),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/detrap_checker.sv =====
// Port-level assertions for the differential entropy trapezoid unit.
module detrap_checker import detrap_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FEW || out_data.status == ST_NONPOS ||
                  out_data.status == ST_NEG) |-> out_data.entropy == '0)
    else $error("error result carries nonzero entropy");

  a_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FEW |-> out_data.samples_used < USED_W'(2))
    else $error("too-few status with two or more samples");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input not stalled after last item");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind differential_entropy_trapezoid_unit detrap_checker u_detrap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
